/* hw/rtl/linear_probe_hash_insert_assert.svh */
// Assertion shorthands shared by lphi_ctrl and lphi_datapath.
`ifndef LINEAR_PROBE_HASH_INSERT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPHI_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LPHI_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/lphi_pkg.sv */
package lphi_pkg;

  localparam int KEY_BITS = 31;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_PRESENT  = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    req_ready;
    logic    load_req;
    logic    clear_wr;
    logic    advance;
    logic    write_entry;
    logic    set_result;
    status_t result;
    logic    load_out;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_valid;
    logic clear_last;
    logic slot_free;
    logic key_match;
    logic wrap;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* hw/rtl/lphi_if.sv */
interface lphi_req_if #(
  parameter int VALUE_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic [lphi_pkg::KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0]         value;

  modport source (output valid, output key, output value, input ready);
  modport sink (input valid, input key, input value, output ready);
endinterface

interface lphi_rsp_if #(
  parameter int SLOT_BITS  = 10,
  parameter int COUNT_BITS = 11
);
  logic                  valid;
  logic                  ready;
  lphi_pkg::status_t     status;
  logic [SLOT_BITS-1:0]  slot;
  logic [COUNT_BITS-1:0] entry_total;
  logic                  load_reached;

  modport source (output valid, output status, output slot, output entry_total,
                  output load_reached, input ready);
  modport sink (input valid, input status, input slot, input entry_total,
                input load_reached, output ready);
endinterface

interface lphi_cfg_if #(
  parameter int COUNT_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] load_limit;

  modport source (output valid, output load_limit, input ready);
  modport sink (input valid, input load_limit, output ready);
endinterface

/* hw/rtl/lphi_ram.sv */
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/lphi_ctrl.sv */
`include "linear_probe_hash_insert_assert.svh"

module lphi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  lphi_pkg::ctrl_stat_t stat,
  output lphi_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.result = lphi_pkg::STATUS_INSERTED;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.req_ready = 1'b1;
        if (stat.req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_READ;
        end
      end
      // RAM address is presented here, data shows up in ST_CHECK.
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.slot_free) begin
          cmd.write_entry = 1'b1;
          cmd.set_result  = 1'b1;
          cmd.result      = lphi_pkg::STATUS_INSERTED;
          state_next      = ST_DONE;
        end else if (stat.key_match) begin
          cmd.set_result = 1'b1;
          cmd.result     = lphi_pkg::STATUS_PRESENT;
          state_next     = ST_DONE;
        end else if (stat.wrap) begin
          cmd.set_result = 1'b1;
          cmd.result     = lphi_pkg::STATUS_FULL;
          state_next     = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  `LPHI_ASSERT_IMPL(a_write_free, clk, rst, cmd.write_entry, stat.slot_free && state == ST_CHECK)
  `LPHI_ASSERT_NEXT(a_accept_read, clk, rst, cmd.load_req, state == ST_READ)

endmodule

/* hw/rtl/lphi_datapath.sv */
`include "linear_probe_hash_insert_assert.svh"

module lphi_datapath #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int VALUE_BITS    = 8,
  parameter int SLOT_BITS     = 10,
  parameter int COUNT_BITS    = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lphi_pkg::ctrl_cmd_t  cmd,
  output lphi_pkg::ctrl_stat_t stat,
  lphi_req_if.sink             req,
  lphi_rsp_if.source           rsp,
  lphi_cfg_if.sink             cfg
);

  localparam int KEY_BITS    = lphi_pkg::KEY_BITS;
  localparam int KV_BITS     = KEY_BITS + VALUE_BITS;
  localparam int LIMIT_RESET = (TABLE_ENTRIES * 4) / 5;

  logic [SLOT_BITS-1:0]  pos;
  logic [SLOT_BITS-1:0]  pos_inc;
  logic [SLOT_BITS-1:0]  home;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] limit;

  lphi_pkg::status_t     res_status;
  logic [SLOT_BITS-1:0]  res_slot;

  logic                  out_valid;
  lphi_pkg::status_t     out_status;
  logic [SLOT_BITS-1:0]  out_slot;
  logic [COUNT_BITS-1:0] out_total;
  logic                  out_load;

  logic                  valid_we;
  logic                  valid_rdata;
  logic [KV_BITS-1:0]    kv_rdata;

  assign pos_inc  = pos + SLOT_BITS'(1);
  assign valid_we = cmd.clear_wr | cmd.write_entry;

  lphi_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_ENTRIES)
  ) u_valid_ram (
    .clk   (clk),
    .we    (valid_we),
    .addr  (pos),
    .wdata (cmd.write_entry),
    .rdata (valid_rdata)
  );

  lphi_ram #(
    .WIDTH (KV_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_kv_ram (
    .clk   (clk),
    .we    (cmd.write_entry),
    .addr  (pos),
    .wdata ({key_q, value_q}),
    .rdata (kv_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      count     <= '0;
      limit     <= COUNT_BITS'(LIMIT_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.load_limit;
      end
      if (cmd.load_req) begin
        pos <= req.key[SLOT_BITS-1:0];
      end else if (cmd.clear_wr || cmd.advance) begin
        pos <= pos_inc;
      end
      if (cmd.write_entry) begin
        count <= count + COUNT_BITS'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      home    <= req.key[SLOT_BITS-1:0];
      key_q   <= req.key;
      value_q <= req.value;
    end
    if (cmd.set_result) begin
      res_status <= cmd.result;
      res_slot   <= (cmd.result == lphi_pkg::STATUS_FULL) ? '0 : pos;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_total  <= count;
      out_load   <= (count >= limit);
    end
  end

  assign stat.req_valid  = req.valid;
  assign stat.clear_last = (pos == SLOT_BITS'(TABLE_ENTRIES - 1));
  assign stat.slot_free  = !valid_rdata;
  assign stat.key_match  = (kv_rdata[KV_BITS-1 -: KEY_BITS] == key_q);
  assign stat.wrap       = (pos_inc == home);
  assign stat.out_free   = !out_valid || rsp.ready;

  assign req.ready        = cmd.req_ready;
  assign cfg.ready        = !rst;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot         = out_slot;
  assign rsp.entry_total  = out_total;
  assign rsp.load_reached = out_load;

  `LPHI_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || rsp.ready)
  `LPHI_ASSERT_NEXT(a_count_hold, clk, rst, !cmd.write_entry, $stable(count))
  `LPHI_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= TABLE_ENTRIES)

endmodule

/* hw/rtl/linear_probe_hash_insert.sv */
// Channel  Role    Words carried
// req      sink    key, value (insert request)
// rsp      source  status, slot, entry_total, load_reached
// cfg      sink    load_limit (ready whenever rst is low)
//
// After reset the valid marks are swept one slot a cycle, so req is not ready until the
// sweep has cleared the last slot; cfg writes are taken throughout the sweep.
// Each probed slot passes through ST_READ (RAM read) and then ST_CHECK (compare); rsp valid
// rises in the same cycle that req is ready again, once ST_DONE has loaded the result into
// the output register. A stalled rsp holds one result in the output register and the next
// one in the datapath result registers while the controller waits in ST_DONE.
module linear_probe_hash_insert #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int VALUE_BITS    = 8
) (
  input logic         clk,
  input logic         rst,
  lphi_req_if.sink    req,
  lphi_rsp_if.source  rsp,
  lphi_cfg_if.sink    cfg
);

  localparam int SLOT_BITS  = $clog2(TABLE_ENTRIES);
  localparam int COUNT_BITS = $clog2(TABLE_ENTRIES + 1);

  lphi_pkg::ctrl_cmd_t  cmd;
  lphi_pkg::ctrl_stat_t stat;

  lphi_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  lphi_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_BITS    (VALUE_BITS),
    .SLOT_BITS     (SLOT_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg)
  );

endmodule
